// ===== design/reno_congestion_window_sender_macros.svh =====
// assertion macros shared by the congestion window sender
// no dependencies; included by the files that carry assertions
`ifndef RENO_CONGESTION_WINDOW_SENDER_MACROS_SVH
`define RENO_CONGESTION_WINDOW_SENDER_MACROS_SVH

// clocked property, disabled while reset is asserted
`define RCWS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define RCWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    `RCWS_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== design/rcws_pkg.sv =====
// types, codes and constants of the congestion window sender
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rcws_pkg;

    localparam int SEQ_W      = 15;
    localparam int WIN_W      = 14;
    localparam int LEN_W      = 10;
    localparam int ACK_W      = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int INFLIGHT_W = 6;
    localparam int TIMER_W    = 16;
    localparam int RTO_W      = 14;
    localparam int ABORT_W    = 16;
    localparam int DUP_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int RING_DEPTH_DEFAULT = 32;
    localparam int SEQ_MODULUS        = 25601;
    localparam int SEGMENT_BYTES      = 512;
    localparam int SEG_SHIFT          = $clog2(SEGMENT_BYTES);

    localparam int WIN_MAX      = 16383;
    localparam int WIN_CAP      = 20 * SEGMENT_BYTES;
    localparam int THRESH_FLOOR = 2 * SEGMENT_BYTES;
    localparam int RECOVERY_ADD = 3 * SEGMENT_BYTES;
    localparam int THRESH_RESET = 10 * SEGMENT_BYTES;

    localparam int RETRANSMIT_RESET = 500;
    localparam int ABORT_RESET      = 10000;

    // avoidance growth numerator and the quotient width it needs
    localparam int DIVIDEND = SEGMENT_BYTES * SEGMENT_BYTES;
    localparam int QUO_W    = $clog2(DIVIDEND + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SENT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAST      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ABORT     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ACK_DONE  = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_SEQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRANSMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT      = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [LEN_W-1:0] segment_length;
        logic [ACK_W-1:0] ack_number;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SEQ_W-1:0]      segment_sequence;
        logic [WIN_W-1:0]      congestion_window;
        logic [WIN_W-1:0]      slow_start_threshold;
        logic [INFLIGHT_W-1:0] in_flight;
        logic                  input_done;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_CHECK,
        S_POP_WAIT,
        S_DIV
    } state_t;

endpackage

// ===== design/rcws_ring_mem.sv =====
// ring of in-flight sequence numbers: one write port, one registered read port
// depends on rcws_pkg for the entry width
`timescale 1ns / 1ps

module rcws_ring_mem #(
    parameter int RING_DEPTH = rcws_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(RING_DEPTH)-1:0]   waddr,
    input  logic [rcws_pkg::SEQ_W-1:0]      wdata,
    input  logic [$clog2(RING_DEPTH)-1:0]   raddr,
    output logic [rcws_pkg::SEQ_W-1:0]      rdata
);
    import rcws_pkg::*;

    logic [SEQ_W-1:0] mem [RING_DEPTH];
    logic [SEQ_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rcws_div.sv =====
// restoring divider for avoidance growth, one quotient bit per cycle
// depends on rcws_pkg for the constant numerator and widths
`timescale 1ns / 1ps

module rcws_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rcws_pkg::WIN_W-1:0]  divisor,
    output logic [rcws_pkg::QUO_W-1:0]  quotient,
    output logic                        done,
    output logic                        running
);
    import rcws_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [WIN_W-1:0] div_reg;
    logic [WIN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WIN_W:0]   trial;
    logic [WIN_W:0]   diff;

    // shift the next numerator bit into the partial remainder
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = QUO_W'(DIVIDEND);
            cnt_next = CNT_W'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[WIN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
    assign running  = (cnt_reg != '0);

endmodule

// ===== design/reno_congestion_window_sender.sv =====
// top level of the reno congestion window sender: command sequencer and window state
// depends on rcws_pkg, rcws_ring_mem, rcws_div and the assertion macro header
`timescale 1ns / 1ps
// sequence: tick and send give a registered result from the exec state, as does an ack that
//   pops nothing; an ack that pops runs pop_check and pop_wait once per popped entry, plus
//   a run of the serial divider per pop that grows the window in avoidance; the registered
//   ring read port paces each pop
// throughput: one item at a time; the next item is taken in the cycle the result shows
// results are a one-cycle strobe (done); the receiver cannot stall
// reset: asynchronous, active low; window 512, threshold 5120, empty ring, no clearing pass

`include "reno_congestion_window_sender_macros.svh"

module reno_congestion_window_sender #(
    parameter int RING_DEPTH = rcws_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  rcws_pkg::request_t              request,
    // result channel
    output logic                            done,
    output rcws_pkg::result_t               result,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcws_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rcws_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SEGS_W = WIN_W - SEG_SHIFT;
    localparam int CMP_W = CNT_W + SEGS_W;

    // control state
    state_t             state_reg, state_next;
    logic               done_reg, done_next;

    // latched item
    request_t           req_reg;

    // configuration
    logic [RTO_W-1:0]   rto_reg;
    logic [ABORT_W-1:0] abort_reg;

    // sender state
    logic [AW-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SEQ_W-1:0]   nseq_reg, nseq_next;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [WIN_W-1:0]   thr_reg, thr_next;
    logic [DUP_W-1:0]   dup_reg, dup_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               fin_reg, fin_next;

    // result payload
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SEQ_W-1:0]    seg_reg, seg_next;

    // ring memory port
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [SEQ_W-1:0]   mem_rdata;

    // divider port
    logic               div_start;
    logic [QUO_W-1:0]   div_quo;
    logic               div_done;
    logic               div_busy;

    // decisions shared by the sequencer and the datapath
    logic               ring_empty;
    logic               head_match;
    logic               pop_done;
    logic               to_pop;
    logic [WIN_W-1:0]   win_eff;
    logic               grow_div;

    // derived arithmetic
    logic [WIN_W-1:0]   halved;
    logic [WIN_W:0]     win_plus_seg;
    logic [WIN_W:0]     eff_plus_seg;
    logic [WIN_W:0]     recov_sum;
    logic [QUO_W:0]     quo_sum;
    logic [CNT_W:0]     tail_sum;
    logic [LEN_W-1:0]   len_clamped;
    logic [SEQ_W:0]     seq_sum;
    logic [TIMER_W-1:0] timer_inc;
    logic [DUP_W-1:0]   dup_inc;
    logic               send_refused;
    logic [SEQ_W:0]     cfg_seq_ext;

    //------------------------------------------------------------------
    // ring memory: read port always follows the head entry
    //------------------------------------------------------------------
    rcws_ring_mem #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (nseq_reg),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    //------------------------------------------------------------------
    // serial divider for 512*512 / cwnd
    //------------------------------------------------------------------
    rcws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (win_reg),
        .quotient (div_quo),
        .done     (div_done),
        .running  (div_busy)
    );

    //------------------------------------------------------------------
    // shared decisions
    //------------------------------------------------------------------
    assign ring_empty = (count_reg == '0);
    // head data is valid in exec and pop_check (the registered read port already holds the head entry)
    assign head_match = (req_reg.ack_number == ACK_W'(mem_rdata));
    assign pop_done   = ring_empty || head_match;
    assign to_pop     = (req_reg.command == CMD_ACK) && !ring_empty && !head_match;

    // recovery exit sets the window back to the threshold before growth
    assign win_eff  = (dup_reg >= DUP_W'(3)) ? thr_reg : win_reg;
    assign grow_div = (win_eff < WIN_W'(WIN_CAP)) && (win_eff > thr_reg) && (win_eff != '0);

    // threshold halving with a floor of two segments
    assign halved = ((win_reg >> 1) > WIN_W'(THRESH_FLOOR)) ? (win_reg >> 1)
                                                           : WIN_W'(THRESH_FLOOR);

    assign win_plus_seg = {1'b0, win_reg} + (WIN_W+1)'(SEGMENT_BYTES);
    assign eff_plus_seg = {1'b0, win_eff} + (WIN_W+1)'(SEGMENT_BYTES);
    assign recov_sum    = {1'b0, halved} + (WIN_W+1)'(RECOVERY_ADD);
    assign quo_sum      = (QUO_W+1)'(win_reg) + {1'b0, div_quo};

    // tail slot, head + count reduced once by the depth
    assign tail_sum = (CNT_W+1)'(head_reg) + {1'b0, count_reg};
    always_comb
    begin
        if (tail_sum >= (CNT_W+1)'(RING_DEPTH))
        begin
            mem_waddr = AW'(tail_sum - (CNT_W+1)'(RING_DEPTH));
        end
        else
        begin
            mem_waddr = AW'(tail_sum);
        end
    end

    assign len_clamped = (req_reg.segment_length > LEN_W'(SEGMENT_BYTES))
                         ? LEN_W'(SEGMENT_BYTES) : req_reg.segment_length;
    assign seq_sum     = {1'b0, nseq_reg} + (SEQ_W+1)'(len_clamped);

    assign timer_inc = (timer_reg != '1) ? timer_reg + TIMER_W'(1) : timer_reg;
    assign dup_inc   = (dup_reg != '1) ? dup_reg + DUP_W'(1) : dup_reg;

    // refused while finished, ring full or window full
    assign send_refused = fin_reg || (count_reg >= CNT_W'(RING_DEPTH)) ||
                          (CMP_W'(count_reg) >= CMP_W'(win_reg[WIN_W-1:SEG_SHIFT]));

    assign cfg_seq_ext = {1'b0, cfg_data[SEQ_W-1:0]};

    //------------------------------------------------------------------
    // next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = to_pop ? S_POP_CHECK : S_IDLE;
            end
            S_POP_CHECK:
            begin
                if (pop_done)
                begin
                    state_next = S_IDLE;
                end
                else if (grow_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                // new head address goes to the memory this cycle
                state_next = S_POP_CHECK;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_POP_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // sequencer outputs
    //------------------------------------------------------------------
    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        done_next = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            S_EXEC:
            begin
                done_next = !to_pop;
            end
            S_POP_CHECK:
            begin
                done_next = pop_done;
                div_start = !pop_done && grow_div;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    //------------------------------------------------------------------
    // datapath
    //------------------------------------------------------------------
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        nseq_next   = nseq_reg;
        win_next    = win_reg;
        thr_next    = thr_reg;
        dup_next    = dup_reg;
        timer_next  = timer_reg;
        fin_next    = fin_reg;
        status_next = status_reg;
        seg_next    = seg_reg;
        mem_we      = 1'b0;

        case (state_reg)
            S_EXEC:
            begin
                status_next = ST_IDLE;
                seg_next    = '0;
                case (req_reg.command)
                    CMD_TICK:
                    begin
                        // timer only ages while segments are in flight
                        if (!ring_empty)
                        begin
                            timer_next = timer_inc;
                            if (timer_inc >= abort_reg)
                            begin
                                status_next = ST_ABORT;
                            end
                            else if (timer_inc > TIMER_W'(rto_reg))
                            begin
                                status_next = ST_TIMEOUT;
                                seg_next    = mem_rdata;
                                thr_next    = halved;
                                win_next    = WIN_W'(SEGMENT_BYTES);
                                timer_next  = '0;
                            end
                        end
                    end
                    CMD_SEND:
                    begin
                        if (send_refused)
                        begin
                            status_next = ST_REFUSED;
                        end
                        else if (req_reg.segment_length == '0)
                        begin
                            // end of file, nothing pushed
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            if (ring_empty)
                            begin
                                timer_next = '0;
                            end
                            mem_we      = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_SENT;
                            seg_next    = nseq_reg;
                            if (seq_sum >= (SEQ_W+1)'(SEQ_MODULUS))
                            begin
                                nseq_next = SEQ_W'(seq_sum - (SEQ_W+1)'(SEQ_MODULUS));
                            end
                            else
                            begin
                                nseq_next = SEQ_W'(seq_sum);
                            end
                            if (len_clamped < LEN_W'(SEGMENT_BYTES))
                            begin
                                fin_next = 1'b1;
                            end
                        end
                    end
                    CMD_ACK:
                    begin
                        status_next = ST_ACK_DONE;
                        timer_next  = '0;
                        if (!ring_empty && head_match)
                        begin
                            // duplicate ack
                            dup_next = dup_inc;
                            if (dup_inc == DUP_W'(3))
                            begin
                                thr_next    = halved;
                                win_next    = (recov_sum > (WIN_W+1)'(WIN_MAX))
                                              ? WIN_W'(WIN_MAX) : WIN_W'(recov_sum);
                                status_next = ST_FAST;
                                seg_next    = mem_rdata;
                            end
                            else if (dup_inc > DUP_W'(3) && win_reg < WIN_W'(WIN_CAP))
                            begin
                                win_next = (win_plus_seg > (WIN_W+1)'(WIN_MAX))
                                           ? WIN_W'(WIN_MAX) : WIN_W'(win_plus_seg);
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_IDLE;
                    end
                endcase
            end
            S_POP_CHECK:
            begin
                if (pop_done)
                begin
                    dup_next = '0;
                end
                else
                begin
                    head_next  = (head_reg == AW'(RING_DEPTH - 1)) ? '0
                                                                   : head_reg + AW'(1);
                    count_next = count_reg - CNT_W'(1);
                    if (dup_reg >= DUP_W'(3))
                    begin
                        dup_next = '0;
                    end
                    if (win_eff >= WIN_W'(WIN_CAP))
                    begin
                        win_next = win_eff;
                    end
                    else if (win_eff <= thr_reg)
                    begin
                        // slow start
                        win_next = (eff_plus_seg > (WIN_W+1)'(WIN_MAX))
                                   ? WIN_W'(WIN_MAX) : WIN_W'(eff_plus_seg);
                    end
                    else
                    begin
                        // avoidance: window set to win_eff; the divisor is the window from before this update
                        win_next = win_eff;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    win_next = (quo_sum > (QUO_W+1)'(WIN_MAX))
                               ? WIN_W'(WIN_MAX) : WIN_W'(quo_sum);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        // start sequence write loads the next sequence
        if (cfg_valid && cfg_index == REG_START_SEQ)
        begin
            if (cfg_seq_ext >= (SEQ_W+1)'(SEQ_MODULUS))
            begin
                nseq_next = SEQ_W'(cfg_seq_ext - (SEQ_W+1)'(SEQ_MODULUS));
            end
            else
            begin
                nseq_next = cfg_data[SEQ_W-1:0];
            end
        end
    end

    //------------------------------------------------------------------
    // registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            rto_reg       <= RTO_W'(RETRANSMIT_RESET);
            abort_reg     <= ABORT_W'(ABORT_RESET);
            head_reg      <= '0;
            count_reg     <= '0;
            nseq_reg      <= '0;
            win_reg       <= WIN_W'(SEGMENT_BYTES);
            thr_reg       <= WIN_W'(THRESH_RESET);
            dup_reg       <= '0;
            timer_reg     <= '0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            nseq_reg  <= nseq_next;
            win_reg   <= win_next;
            thr_reg   <= thr_next;
            dup_reg   <= dup_next;
            timer_reg <= timer_next;
            fin_reg   <= fin_next;
            if (cfg_valid)
            begin
                // the start sequence only acts through the next sequence above
                case (cfg_index)
                    REG_RETRANSMIT: rto_reg   <= cfg_data[RTO_W-1:0];
                    REG_ABORT:      abort_reg <= cfg_data[ABORT_W-1:0];
                    default:        rto_reg   <= rto_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        seg_reg    <= seg_next;
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= request;
        end
    end

    //------------------------------------------------------------------
    // ports
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign done      = done_reg;

    assign result.status               = status_reg;
    assign result.segment_sequence     = seg_reg;
    assign result.congestion_window    = win_reg;
    assign result.slow_start_threshold = thr_reg;
    assign result.in_flight            = INFLIGHT_W'(count_reg);
    assign result.input_done           = fin_reg;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    `RCWS_ASSERT_IMP(a_done_after_work, clk, rst_n, done_reg, $past(busy),
                     "result without work")
    `RCWS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(RING_DEPTH), "ring overfilled")
    `RCWS_ASSERT_IMP(a_div_in_state, clk, rst_n, div_busy, state_reg == S_DIV, "divider stray")
    `RCWS_ASSERT(a_empty_stops_pop, clk, rst_n,
                 (state_reg == S_POP_CHECK && ring_empty) |=> (state_reg == S_IDLE),
                 "pop past empty ring")

endmodule
